// ----- design/clbs_pkg.sv -----
// Shared types and codes for the cellular link bring-up sequencer.
// No dependencies; imported by the step logic and the top level.
`default_nettype none

package clbs_pkg;

  // phase codes
  localparam logic [2:0] PH_SYNC    = 3'd0;
  localparam logic [2:0] PH_SIM     = 3'd1;
  localparam logic [2:0] PH_REG     = 3'd2;
  localparam logic [2:0] PH_ATTACH  = 3'd3;
  localparam logic [2:0] PH_ONLINE  = 3'd4;
  localparam logic [2:0] PH_ATREADY = 3'd5;
  localparam logic [2:0] PH_BACKOFF = 3'd6;

  // error codes
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_NO_MODEM = 3'd1;
  localparam logic [2:0] ERR_SIM      = 3'd2;
  localparam logic [2:0] ERR_NO_APN   = 3'd3;
  localparam logic [2:0] ERR_ATTACH   = 3'd4;
  localparam logic [2:0] ERR_LINK     = 3'd5;

  // status flag bit positions
  localparam int FL_MODEM = 0;
  localparam int FL_SIM   = 1;
  localparam int FL_REG   = 2;
  localparam int FL_DATA  = 3;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_AT_ONLY      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_APN_READY    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STATUS_PER   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RETRY_PER    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BACKOFF_FLR  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BACKOFF_CEIL = 3'd5;

  // register reset values
  localparam logic [31:0] STATUS_PER_RST   = 32'd10000;
  localparam logic [31:0] RETRY_PER_RST    = 32'd2000;
  localparam logic [31:0] BACKOFF_FLR_RST  = 32'd5000;
  localparam logic [31:0] BACKOFF_CEIL_RST = 32'd300000;

  localparam logic [4:0]        SIG_MAX  = 5'd31;
  localparam logic signed [7:0] DBM_BASE = -8'sd113;

  typedef struct packed {
    logic        at_only_mode;
    logic        apn_ready;
    logic [31:0] status_period_ms;
    logic [31:0] retry_period_ms;
    logic [31:0] backoff_floor_ms;
    logic [31:0] backoff_ceiling_ms;
  } cfg_t;

  typedef struct packed {
    logic [31:0]        now_ms;
    logic               at_answered;
    logic               sim_card_ready;
    logic               network_seen;
    logic               attach_succeeded;
    logic               data_link_up;
    logic signed [15:0] raw_signal;
  } tick_t;

  typedef struct packed {
    logic [2:0]        phase;
    logic [31:0]       deadline_ms;
    logic              start_pending;
    logic [31:0]       retry_delay_ms;
    logic [31:0]       signal_stamp_ms;
    logic [3:0]        status_flags;
    logic [2:0]        error_reg;
    logic signed [5:0] quality_reg;
    logic signed [7:0] dbm_reg;
    logic [31:0]       stamp_ms;
  } seq_state_t;

  // per-step strobes that travel with the next state
  typedef struct packed {
    logic stepped;
    logic drop_request;
  } step_flags_t;

endpackage

`default_nettype wire

// ----- design/clbs_tick_if.sv -----
// Request channel carrying one tick: time stamp and modem probe outcomes.
// No dependencies.
`default_nettype none

interface clbs_tick_if;
  logic               valid;
  logic               ready;
  logic [31:0]        now_ms;
  logic               at_answered;
  logic               sim_card_ready;
  logic               network_seen;
  logic               attach_succeeded;
  logic               data_link_up;
  logic signed [15:0] raw_signal;

  modport source (output valid, now_ms, at_answered, sim_card_ready, network_seen,
                  attach_succeeded, data_link_up, raw_signal, input ready);
  modport sink   (input valid, now_ms, at_answered, sim_card_ready, network_seen,
                  attach_succeeded, data_link_up, raw_signal, output ready);
endinterface

`default_nettype wire

// ----- design/clbs_result_if.sv -----
// Result channel carrying the sequencer status after each tick.
// No dependencies.
`default_nettype none

interface clbs_result_if;
  logic               valid;
  logic               ready;
  logic               stepped;
  logic [2:0]         link_state;
  logic               modem_present;
  logic               sim_ok;
  logic               registered;
  logic               data_connected;
  logic [2:0]         error_code;
  logic signed [5:0]  signal_level;
  logic signed [7:0]  signal_dbm;
  logic [31:0]        updated_at;
  logic               drop_request;

  modport source (output valid, stepped, link_state, modem_present, sim_ok, registered,
                  data_connected, error_code, signal_level, signal_dbm, updated_at,
                  drop_request, input ready);
  modport sink   (input valid, stepped, link_state, modem_present, sim_ok, registered,
                  data_connected, error_code, signal_level, signal_dbm, updated_at,
                  drop_request, output ready);
endinterface

`default_nettype wire

// ----- design/clbs_cfg_if.sv -----
// Configuration write channel: register index and write data.
// No dependencies.
`default_nettype none

interface clbs_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- design/clbs_step.sv -----
// Next-state logic for one tick of the bring-up sequencer.
// Depends on clbs_pkg.
`default_nettype none

module clbs_step
  import clbs_pkg::*;
(
  input  var cfg_t        cfg,
  input  var seq_state_t  state,
  input  var tick_t       tick,
  output seq_state_t      state_next,
  output step_flags_t     flags
);

  logic [31:0] since_deadline;
  logic [31:0] since_signal;
  logic        due;
  logic        sig_due;
  logic        sig_in_range;
  logic [32:0] doubled;
  logic [31:0] delay_next;
  logic        want_signal;
  logic        enter_backoff;
  logic [2:0]  backoff_code;

  assign since_deadline = tick.now_ms - state.deadline_ms;
  assign since_signal   = tick.now_ms - state.signal_stamp_ms;
  // wrap-safe: deadline passed when the signed difference is not negative
  assign due     = state.start_pending || !since_deadline[31];
  assign sig_due = (state.signal_stamp_ms == '0) || (since_signal >= cfg.status_period_ms);
  assign sig_in_range = !tick.raw_signal[15] && (tick.raw_signal[14:5] == '0);

  assign doubled    = {state.retry_delay_ms, 1'b0};
  assign delay_next = (doubled > {1'b0, cfg.backoff_ceiling_ms}) ? cfg.backoff_ceiling_ms
                                                                 : doubled[31:0];

  always_comb begin
    state_next         = state;
    flags.stepped      = 1'b0;
    flags.drop_request = 1'b0;
    want_signal        = 1'b0;
    enter_backoff      = 1'b0;
    backoff_code       = ERR_NONE;

    if (due) begin
      flags.stepped            = 1'b1;
      state_next.start_pending = 1'b0;
      state_next.stamp_ms      = tick.now_ms;
      unique case (state.phase)
        PH_SYNC: begin
          state_next.status_flags[FL_MODEM] = tick.at_answered;
          if (tick.at_answered) begin
            state_next.error_reg   = ERR_NONE;
            state_next.phase       = PH_SIM;
            state_next.deadline_ms = tick.now_ms;
          end else begin
            enter_backoff = 1'b1;
            backoff_code  = ERR_NO_MODEM;
          end
        end
        PH_SIM: begin
          state_next.status_flags[FL_SIM] = tick.sim_card_ready;
          want_signal = 1'b1;
          if (!tick.sim_card_ready) begin
            enter_backoff = 1'b1;
            backoff_code  = ERR_SIM;
          end else if (cfg.at_only_mode) begin
            state_next.phase       = PH_ATREADY;
            state_next.deadline_ms = tick.now_ms + cfg.status_period_ms;
          end else begin
            state_next.phase       = PH_REG;
            state_next.deadline_ms = tick.now_ms;
          end
        end
        PH_REG: begin
          state_next.status_flags[FL_REG] = tick.network_seen;
          want_signal = 1'b1;
          if (tick.network_seen) begin
            state_next.phase       = PH_ATTACH;
            state_next.deadline_ms = tick.now_ms;
          end else begin
            state_next.deadline_ms = tick.now_ms + cfg.retry_period_ms;
          end
        end
        PH_ATTACH: begin
          if (!cfg.apn_ready) begin
            enter_backoff = 1'b1;
            backoff_code  = ERR_NO_APN;
          end else if (tick.attach_succeeded) begin
            state_next.status_flags[FL_DATA] = 1'b1;
            state_next.phase          = PH_ONLINE;
            state_next.deadline_ms    = tick.now_ms + cfg.status_period_ms;
            state_next.retry_delay_ms = cfg.backoff_floor_ms;
          end else begin
            enter_backoff = 1'b1;
            backoff_code  = ERR_ATTACH;
          end
        end
        PH_ONLINE: begin
          state_next.status_flags[FL_REG]  = tick.network_seen;
          state_next.status_flags[FL_DATA] = tick.data_link_up;
          want_signal = 1'b1;
          if (!tick.network_seen || !tick.data_link_up) begin
            flags.drop_request = 1'b1;
            enter_backoff = 1'b1;
            backoff_code  = ERR_LINK;
          end else begin
            state_next.deadline_ms = tick.now_ms + cfg.status_period_ms;
          end
        end
        PH_ATREADY: begin
          state_next.status_flags[FL_SIM] = tick.sim_card_ready;
          want_signal = 1'b1;
          state_next.deadline_ms = tick.now_ms + cfg.status_period_ms;
        end
        PH_BACKOFF: begin
          state_next.phase       = PH_SYNC;
          state_next.deadline_ms = tick.now_ms;
        end
        default: begin
          // unreachable phase only records the time stamp
        end
      endcase

      if (want_signal && sig_due) begin
        state_next.signal_stamp_ms = tick.now_ms;
        if (sig_in_range) begin
          state_next.quality_reg = $signed({1'b0, tick.raw_signal[4:0]});
          state_next.dbm_reg     = DBM_BASE + $signed({2'b00, tick.raw_signal[4:0], 1'b0});
        end else begin
          state_next.quality_reg = -6'sd1;
          state_next.dbm_reg     = '0;
        end
      end

      if (enter_backoff) begin
        state_next.status_flags[FL_DATA] = 1'b0;
        state_next.error_reg      = backoff_code;
        state_next.phase          = PH_BACKOFF;
        state_next.deadline_ms    = tick.now_ms + state.retry_delay_ms;
        state_next.retry_delay_ms = delay_next;
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/cellular_link_bringup_sequencer.sv -----
// Cellular link bring-up sequencer: top level with tick and result stages.
// Depends on clbs_pkg, the three channel interfaces and clbs_step.
//
// Usage:
//   tick   - one request per tick: time in ms and the modem probe outcomes.
//   result - one request per tick: step strobe, phase, held flags, error code,
//            signal level and dBm, time of the last step, drop request.
//   cfg    - register writes by index, always ready; write only while idle.
// Each tick yields exactly one result, in order. A tick is registered in the
// input stage on acceptance and evaluated against the sequencer state once
// the output register is free or its result is being taken; the result is
// then registered in the output register, which drives result.valid. One
// tick per cycle is sustained while the receiver takes each result; the
// single next-state evaluation per cycle is the only loop. When the receiver
// stalls, the output register holds its result and the input stage still
// takes one more tick; then tick.ready drops until the result is taken.
// Reset (rst, synchronous) loads register defaults, returns to sync phase,
// arms the first-tick step and empties both stages.
`default_nettype none

module cellular_link_bringup_sequencer
  import clbs_pkg::*;
(
  input  wire            clk,
  input  wire            rst,
  clbs_tick_if.sink      tick,
  clbs_result_if.source  result,
  clbs_cfg_if.sink       cfg
);

  cfg_t        cfg_regs;
  seq_state_t  state;
  seq_state_t  state_next;
  step_flags_t step_flags;
  tick_t       tick_q;
  logic        tick_valid;
  logic        out_valid;
  logic        advance;

  assign advance    = tick_valid && (!out_valid || result.ready);
  assign tick.ready = !tick_valid || advance;
  assign cfg.ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.at_only_mode       <= 1'b0;
      cfg_regs.apn_ready          <= 1'b1;
      cfg_regs.status_period_ms   <= STATUS_PER_RST;
      cfg_regs.retry_period_ms    <= RETRY_PER_RST;
      cfg_regs.backoff_floor_ms   <= BACKOFF_FLR_RST;
      cfg_regs.backoff_ceiling_ms <= BACKOFF_CEIL_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_AT_ONLY:      cfg_regs.at_only_mode       <= cfg.data[0];
        REG_APN_READY:    cfg_regs.apn_ready          <= cfg.data[0];
        REG_STATUS_PER:   cfg_regs.status_period_ms   <= cfg.data;
        REG_RETRY_PER:    cfg_regs.retry_period_ms    <= cfg.data;
        REG_BACKOFF_FLR:  cfg_regs.backoff_floor_ms   <= cfg.data;
        REG_BACKOFF_CEIL: cfg_regs.backoff_ceiling_ms <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_valid <= 1'b0;
    end else if (tick.valid && tick.ready) begin
      tick_valid <= 1'b1;
    end else if (advance) begin
      tick_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      tick_q.now_ms           <= tick.now_ms;
      tick_q.at_answered      <= tick.at_answered;
      tick_q.sim_card_ready   <= tick.sim_card_ready;
      tick_q.network_seen     <= tick.network_seen;
      tick_q.attach_succeeded <= tick.attach_succeeded;
      tick_q.data_link_up     <= tick.data_link_up;
      tick_q.raw_signal       <= tick.raw_signal;
    end
  end

  clbs_step u_step (
    .cfg        (cfg_regs),
    .state      (state),
    .tick       (tick_q),
    .state_next (state_next),
    .flags      (step_flags)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase           <= PH_SYNC;
      state.deadline_ms     <= '0;
      state.start_pending   <= 1'b1;
      state.retry_delay_ms  <= BACKOFF_FLR_RST;
      state.signal_stamp_ms <= '0;
      state.status_flags    <= '0;
      state.error_reg       <= ERR_NONE;
      state.quality_reg     <= '0;
      state.dbm_reg         <= '0;
      state.stamp_ms        <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.stepped        <= step_flags.stepped;
      result.drop_request   <= step_flags.drop_request;
      result.link_state     <= state_next.phase;
      result.modem_present  <= state_next.status_flags[FL_MODEM];
      result.sim_ok         <= state_next.status_flags[FL_SIM];
      result.registered     <= state_next.status_flags[FL_REG];
      result.data_connected <= state_next.status_flags[FL_DATA];
      result.error_code     <= state_next.error_reg;
      result.signal_level   <= state_next.quality_reg;
      result.signal_dbm     <= state_next.dbm_reg;
      result.updated_at     <= state_next.stamp_ms;
    end
  end

  assign result.valid = out_valid;

endmodule

`default_nettype wire
